>>> sv/mmpn_pkg.sv
// ----------------------------------------------------------------------------
// Memory map page normaliser: shared package
// Widths, codes, record types and small helpers used across the block.
// ----------------------------------------------------------------------------
package mmpn_pkg;

	localparam int PAGE_SHIFT  = 12;
	localparam int TABLE_SLOTS = 64;

	localparam int ADDR_W     = 64;
	localparam int MAX_ADDR_W = 63;
	localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
	localparam int SLOT_CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int OUT_PAGE_W = 52;
	localparam int OUT_SLOT_W = 6;
	localparam int KIND_W     = 4;
	localparam int OUT_KIND_W = 3;
	localparam int STATUS_W   = 2;

	localparam logic [ADDR_W-1:0] PAGE_MASK = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
	localparam logic [MAX_ADDR_W-1:0] MAX_ADDR_RESET = MAX_ADDR_W'(64'd4294967295);

	localparam logic [KIND_W-1:0] KIND_AVAIL = 4'd1;
	localparam logic [KIND_W-1:0] KIND_FIRST = 4'd1;
	localparam logic [KIND_W-1:0] KIND_LAST  = 4'd5;
	localparam logic [OUT_KIND_W-1:0] KIND_GAP  = 3'd2;
	localparam logic [OUT_KIND_W-1:0] KIND_NONE = 3'd0;

	localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_UNSUPPORTED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] length;
		logic [KIND_W-1:0] kind;
		logic              last;
	} in_item_t;

	typedef struct packed {
		logic                  drop;
		logic                  unsup;
		logic                  resv;
		logic                  nonempty;
		logic                  last;
		logic [OUT_KIND_W-1:0] kind;
		logic [PAGE_W-1:0]     sp;
		logic [PAGE_W-1:0]     ep;
	} aligned_t;

	typedef struct packed {
		logic [OUT_PAGE_W-1:0] start_page;
		logic [OUT_PAGE_W-1:0] page_count;
		logic                  is_reserved;
		logic [OUT_KIND_W-1:0] out_kind;
		logic [OUT_SLOT_W-1:0] slot_index;
		logic [OUT_PAGE_W-1:0] highest_page;
		logic [STATUS_W-1:0]   status;
	} out_rec_t;

	typedef struct packed {
		out_rec_t   first;
		out_rec_t   second;
		logic [1:0] count;
	} rec_pair_t;

	function automatic logic [OUT_PAGE_W-1:0] to_out_page(input logic [PAGE_W-1:0] p);
		logic [ADDR_W-1:0] wide;
		wide = ADDR_W'(p);
		return wide[OUT_PAGE_W-1:0];
	endfunction

	function automatic logic [OUT_SLOT_W-1:0] to_out_slot(input logic [SLOT_CNT_W-1:0] s);
		logic [ADDR_W-1:0] wide;
		wide = ADDR_W'(s);
		return wide[OUT_SLOT_W-1:0];
	endfunction

endpackage

>>> sv/mmpn_align.sv
// ----------------------------------------------------------------------------
// Memory map page normaliser: clip and align
// Clips an entry against the highest address and aligns it to page frames.
// ----------------------------------------------------------------------------
module mmpn_align (
	input  mmpn_pkg::in_item_t                    item,
	input  logic [mmpn_pkg::MAX_ADDR_W-1:0]       max_address,
	output mmpn_pkg::aligned_t                    aligned
);

	logic [mmpn_pkg::ADDR_W-1:0] max_ext;
	logic [mmpn_pkg::ADDR_W-1:0] max_p1;
	logic [mmpn_pkg::ADDR_W-1:0] room;
	logic [mmpn_pkg::ADDR_W-1:0] clip_end;
	logic [mmpn_pkg::ADDR_W-1:0] base_up;
	logic [mmpn_pkg::ADDR_W-1:0] end_up;
	logic [mmpn_pkg::ADDR_W-1:0] nb;
	logic [mmpn_pkg::ADDR_W-1:0] ne;
	logic                        resv;
	logic                        nonempty;

	// With the highest address below 2^63 the clipped end never wraps.
	always_comb begin
		max_ext  = {1'b0, max_address};
		max_p1   = max_ext + mmpn_pkg::ADDR_W'(1);
		room     = max_p1 - item.base;
		clip_end = (item.length > room) ? max_p1 : item.base + item.length;
		base_up  = item.base + mmpn_pkg::PAGE_MASK;
		end_up   = clip_end + mmpn_pkg::PAGE_MASK;
		resv     = item.kind != mmpn_pkg::KIND_AVAIL;
		if (resv) begin
			nb       = item.base & ~mmpn_pkg::PAGE_MASK;
			ne       = end_up & ~mmpn_pkg::PAGE_MASK;
			nonempty = ne != nb;
		end else begin
			nb       = base_up & ~mmpn_pkg::PAGE_MASK;
			ne       = clip_end & ~mmpn_pkg::PAGE_MASK;
			nonempty = ne > nb;
		end
	end

	always_comb begin
		aligned.drop     = item.base > max_ext;
		aligned.unsup    = (item.kind < mmpn_pkg::KIND_FIRST) ||
		                   (item.kind > mmpn_pkg::KIND_LAST);
		aligned.resv     = resv;
		aligned.nonempty = nonempty;
		aligned.last     = item.last;
		aligned.kind     = item.kind[mmpn_pkg::OUT_KIND_W-1:0];
		aligned.sp       = nb[mmpn_pkg::ADDR_W-1:mmpn_pkg::PAGE_SHIFT];
		aligned.ep       = nonempty ? ne[mmpn_pkg::ADDR_W-1:mmpn_pkg::PAGE_SHIFT]
		                            : nb[mmpn_pkg::ADDR_W-1:mmpn_pkg::PAGE_SHIFT];
	end

endmodule

>>> sv/mmpn_track.sv
// ----------------------------------------------------------------------------
// Memory map page normaliser: running state and record builder
// Keeps end page, highest page and slot count; builds gap and region records.
// ----------------------------------------------------------------------------
module mmpn_track (
	input  logic               clk,
	input  logic               arst_n,
	input  mmpn_pkg::aligned_t aligned,
	input  logic               advance,
	output mmpn_pkg::rec_pair_t recs
);

	logic [mmpn_pkg::PAGE_W-1:0]     prev_end_q;
	logic [mmpn_pkg::PAGE_W-1:0]     max_end_q;
	logic [mmpn_pkg::SLOT_CNT_W-1:0] slots_q;

	logic [mmpn_pkg::PAGE_W-1:0]     prev_end_d;
	logic [mmpn_pkg::PAGE_W-1:0]     max_end_d;
	logic [mmpn_pkg::SLOT_CNT_W-1:0] slots_d;
	logic [mmpn_pkg::SLOT_CNT_W-1:0] slots_mid;
	logic                            gap;
	logic                            room_gap;
	logic                            room_reg;
	mmpn_pkg::out_rec_t              gap_rec;
	mmpn_pkg::out_rec_t              reg_rec;
	mmpn_pkg::out_rec_t              unsup_rec;

	always_comb begin
		gap        = aligned.sp > prev_end_q;
		room_gap   = slots_q < mmpn_pkg::SLOT_CNT_W'(mmpn_pkg::TABLE_SLOTS);
		slots_mid  = (gap && room_gap) ? slots_q + mmpn_pkg::SLOT_CNT_W'(1) : slots_q;
		room_reg   = slots_mid < mmpn_pkg::SLOT_CNT_W'(mmpn_pkg::TABLE_SLOTS);
		prev_end_d = prev_end_q;
		max_end_d  = max_end_q;
		slots_d    = slots_mid;
		if (aligned.nonempty && room_reg) begin
			prev_end_d = aligned.ep;
			max_end_d  = (aligned.ep > max_end_q) ? aligned.ep : max_end_q;
			slots_d    = slots_mid + mmpn_pkg::SLOT_CNT_W'(1);
		end

		gap_rec.start_page   = mmpn_pkg::to_out_page(prev_end_q);
		gap_rec.page_count   = mmpn_pkg::to_out_page(aligned.sp - prev_end_q);
		gap_rec.is_reserved  = 1'b1;
		gap_rec.out_kind     = mmpn_pkg::KIND_GAP;
		gap_rec.slot_index   = room_gap ? mmpn_pkg::to_out_slot(slots_q) : '0;
		gap_rec.highest_page = mmpn_pkg::to_out_page(max_end_q);
		gap_rec.status       = room_gap ? mmpn_pkg::STATUS_OK : mmpn_pkg::STATUS_FULL;

		reg_rec.start_page   = mmpn_pkg::to_out_page(aligned.sp);
		reg_rec.page_count   = mmpn_pkg::to_out_page(aligned.ep - aligned.sp);
		reg_rec.is_reserved  = aligned.resv;
		reg_rec.out_kind     = aligned.kind;
		reg_rec.slot_index   = room_reg ? mmpn_pkg::to_out_slot(slots_mid) : '0;
		reg_rec.highest_page = mmpn_pkg::to_out_page(max_end_d);
		reg_rec.status       = room_reg ? mmpn_pkg::STATUS_OK : mmpn_pkg::STATUS_FULL;

		unsup_rec.start_page   = '0;
		unsup_rec.page_count   = '0;
		unsup_rec.is_reserved  = 1'b0;
		unsup_rec.out_kind     = mmpn_pkg::KIND_NONE;
		unsup_rec.slot_index   = mmpn_pkg::to_out_slot(slots_q);
		unsup_rec.highest_page = mmpn_pkg::to_out_page(max_end_q);
		unsup_rec.status       = mmpn_pkg::STATUS_UNSUPPORTED;

		recs.first  = gap ? gap_rec : reg_rec;
		recs.second = reg_rec;
		if (aligned.drop) begin
			recs.count = 2'd0;
		end else if (aligned.unsup) begin
			recs.first = unsup_rec;
			recs.count = 2'd1;
		end else begin
			recs.count = {1'b0, gap} + {1'b0, aligned.nonempty};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_end_q <= '0;
			max_end_q  <= '0;
			slots_q    <= '0;
		end else if (advance) begin
			if (aligned.last) begin
				prev_end_q <= '0;
				max_end_q  <= '0;
				slots_q    <= '0;
			end else if (!aligned.drop && !aligned.unsup) begin
				prev_end_q <= prev_end_d;
				max_end_q  <= max_end_d;
				slots_q    <= slots_d;
			end
		end
	end

endmodule

>>> sv/mmpn_outbuf.sv
// ----------------------------------------------------------------------------
// Memory map page normaliser: result buffer
// Holds the one or two records of an entry and hands them out in order.
// ----------------------------------------------------------------------------
module mmpn_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  mmpn_pkg::rec_pair_t recs,
	output logic                free,
	output logic                out_valid,
	input  logic                out_ready,
	output mmpn_pkg::out_rec_t  rec,
	output logic                last_in_run
);

	mmpn_pkg::out_rec_t first_q;
	mmpn_pkg::out_rec_t second_q;
	logic               valid_q;
	logic               two_q;
	logic               sel_q;

	assign out_valid   = valid_q;
	assign rec         = sel_q ? second_q : first_q;
	assign last_in_run = !two_q || sel_q;
	// The buffer can take a new entry in the cycle its final record leaves.
	assign free        = !valid_q || (out_ready && last_in_run);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			two_q   <= 1'b0;
			sel_q   <= 1'b0;
		end else if (load && recs.count != 2'd0) begin
			valid_q <= 1'b1;
			two_q   <= recs.count == 2'd2;
			sel_q   <= 1'b0;
		end else if (valid_q && out_ready) begin
			if (last_in_run) begin
				valid_q <= 1'b0;
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_q  <= recs.first;
			second_q <= recs.second;
		end
	end

endmodule

>>> sv/memory_map_page_normalizer_core.sv
// ----------------------------------------------------------------------------
// Memory map page normaliser core
// Turns boot memory-map entries into page-frame region records with gap fill.
// ----------------------------------------------------------------------------
// A request passes the input register, the align register and the result buffer
// before its first result is valid. Throughput: one entry per cycle while each
// entry gives at most one result and out_ready stays high; an entry with two
// records holds the result buffer until both have left in order. Reset clears all
// running state and valid flags and sets the highest address to 4294967295.
module memory_map_page_normalizer_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wen,
	input  logic [mmpn_pkg::MAX_ADDR_W-1:0]      cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [mmpn_pkg::ADDR_W-1:0]          region_base,
	input  logic [mmpn_pkg::ADDR_W-1:0]          region_length,
	input  logic [mmpn_pkg::KIND_W-1:0]          region_kind,
	input  logic                                 last_entry,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [mmpn_pkg::OUT_PAGE_W-1:0]      start_page,
	output logic [mmpn_pkg::OUT_PAGE_W-1:0]      page_count,
	output logic                                 is_reserved,
	output logic [mmpn_pkg::OUT_KIND_W-1:0]      out_kind,
	output logic [mmpn_pkg::OUT_SLOT_W-1:0]      slot_index,
	output logic [mmpn_pkg::OUT_PAGE_W-1:0]      highest_page,
	output logic [mmpn_pkg::STATUS_W-1:0]        status,
	output logic                                 last_in_run
);

	logic [mmpn_pkg::MAX_ADDR_W-1:0] max_addr_q;
	mmpn_pkg::in_item_t              item_s1;
	logic                            valid_s1;
	mmpn_pkg::aligned_t              aligned_c;
	mmpn_pkg::aligned_t              aligned_s2;
	logic                            valid_s2;
	mmpn_pkg::rec_pair_t             recs_c;
	mmpn_pkg::out_rec_t              rec;
	logic                            out_free;
	logic                            free_s2;
	logic                            advance_s2;
	logic                            take_s1;

	assign advance_s2 = valid_s2 && out_free;
	assign free_s2    = !valid_s2 || out_free;
	assign take_s1    = valid_s1 && free_s2;
	assign in_ready   = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_addr_q <= mmpn_pkg::MAX_ADDR_RESET;
		end else if (cfg_wen) begin
			max_addr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
			if (take_s1) begin
				valid_s2 <= 1'b1;
			end else if (advance_s2) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.base   <= region_base;
			item_s1.length <= region_length;
			item_s1.kind   <= region_kind;
			item_s1.last   <= last_entry;
		end
		if (take_s1) begin
			aligned_s2 <= aligned_c;
		end
	end

	mmpn_align u_align (
		.item        (item_s1),
		.max_address (max_addr_q),
		.aligned     (aligned_c)
	);

	mmpn_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.aligned (aligned_s2),
		.advance (advance_s2),
		.recs    (recs_c)
	);

	mmpn_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (advance_s2),
		.recs        (recs_c),
		.free        (out_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rec         (rec),
		.last_in_run (last_in_run)
	);

	assign start_page   = rec.start_page;
	assign page_count   = rec.page_count;
	assign is_reserved  = rec.is_reserved;
	assign out_kind     = rec.out_kind;
	assign slot_index   = rec.slot_index;
	assign highest_page = rec.highest_page;
	assign status       = rec.status;

endmodule
